// File: rtl/dlfd_pkg.sv
// Shared constants, result type and modulo-100 helper for the decimal-length frame deframer.
`timescale 1ns / 1ps

package dlfd_pkg;

    localparam logic [7:0] START_BYTE      = 8'h53;
    localparam int         SUM_MODULUS     = 100;
    localparam int         LENGTH_OVERHEAD = 5;
    localparam int         MIN_LENGTH      = 6;
    localparam logic [6:0] START_SUM       = 7'(START_BYTE % SUM_MODULUS);

    localparam logic [7:0] DIGIT_LO = 8'h30;
    localparam logic [7:0] DIGIT_HI = 8'h39;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_LEN1 = 3'd1;
    localparam logic [2:0] PH_LEN2 = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CK1  = 3'd4;
    localparam logic [2:0] PH_CK2  = 3'd5;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_MISMATCH = 2'd2;
    localparam logic [1:0] KIND_FORMAT   = 2'd3;

    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [7:0] payload;
        logic [6:0] checksum;
    } result_t;

    // Add a byte to a running sum that is already below 100, keep the result below 100.
    function automatic logic [6:0] add_mod100(input logic [6:0] sum, input logic [7:0] data);
        logic [8:0] total;
        total = {2'b00, sum} + {1'b0, data};
        if (total >= 9'(2 * SUM_MODULUS))
        begin
            total = total - 9'(2 * SUM_MODULUS);
        end
        if (total >= 9'(SUM_MODULUS))
        begin
            total = total - 9'(SUM_MODULUS);
        end
        return total[6:0];
    endfunction

endpackage

// File: rtl/dlfd_core.sv
// Frame phase tracking, length and checksum decode for one byte per step.
`timescale 1ns / 1ps

module dlfd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [7:0]          rx_byte,
    output dlfd_pkg::result_t   step_result
);

    logic [2:0] phase_reg,         phase_next;
    logic [3:0] first_digit_reg,   first_digit_next;
    logic [6:0] frame_length_reg,  frame_length_next;
    logic [6:0] payload_count_reg, payload_count_next;
    logic [6:0] running_sum_reg,   running_sum_next;

    logic       is_digit;
    logic [6:0] sum_added;
    logic [6:0] two_digit;
    logic [6:0] count_inc;
    logic [6:0] data_limit;

    assign is_digit   = rx_byte inside {[dlfd_pkg::DIGIT_LO : dlfd_pkg::DIGIT_HI]};
    assign sum_added  = dlfd_pkg::add_mod100(running_sum_reg, rx_byte);
    assign two_digit  = {first_digit_reg, 3'b000} + {2'b00, first_digit_reg, 1'b0}
                      + {3'b000, rx_byte[3:0]};
    assign count_inc  = payload_count_reg + 7'd1;
    assign data_limit = frame_length_reg - 7'(dlfd_pkg::LENGTH_OVERHEAD);

    always_comb
    begin
        phase_next         = phase_reg;
        first_digit_next   = first_digit_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        running_sum_next   = running_sum_reg;
        step_result        = '{emit: 1'b0, kind: dlfd_pkg::KIND_PAYLOAD,
                               payload: 8'd0, checksum: 7'd0};

        case (phase_reg)
            dlfd_pkg::PH_LEN1:
            begin
                if (!is_digit)
                begin
                    step_result = '{emit: 1'b1, kind: dlfd_pkg::KIND_FORMAT,
                                    payload: 8'd0, checksum: running_sum_reg};
                    phase_next  = dlfd_pkg::PH_HUNT;
                end
                else
                begin
                    first_digit_next = rx_byte[3:0];
                    running_sum_next = sum_added;
                    phase_next       = dlfd_pkg::PH_LEN2;
                end
            end
            dlfd_pkg::PH_LEN2:
            begin
                if (!is_digit)
                begin
                    step_result = '{emit: 1'b1, kind: dlfd_pkg::KIND_FORMAT,
                                    payload: 8'd0, checksum: running_sum_reg};
                    phase_next  = dlfd_pkg::PH_HUNT;
                end
                else
                begin
                    running_sum_next  = sum_added;
                    frame_length_next = two_digit;
                    if (two_digit < 7'(dlfd_pkg::MIN_LENGTH))
                    begin
                        // Too short to hold the header and checksum: the sum includes this digit.
                        step_result = '{emit: 1'b1, kind: dlfd_pkg::KIND_FORMAT,
                                        payload: 8'd0, checksum: sum_added};
                        phase_next  = dlfd_pkg::PH_HUNT;
                    end
                    else
                    begin
                        payload_count_next = 7'd0;
                        phase_next         = dlfd_pkg::PH_DATA;
                    end
                end
            end
            dlfd_pkg::PH_DATA:
            begin
                running_sum_next   = sum_added;
                payload_count_next = count_inc;
                if (count_inc >= data_limit)
                begin
                    phase_next = dlfd_pkg::PH_CK1;
                end
                step_result = '{emit: 1'b1, kind: dlfd_pkg::KIND_PAYLOAD,
                                payload: rx_byte, checksum: 7'd0};
            end
            dlfd_pkg::PH_CK1:
            begin
                if (!is_digit)
                begin
                    step_result = '{emit: 1'b1, kind: dlfd_pkg::KIND_FORMAT,
                                    payload: 8'd0, checksum: running_sum_reg};
                    phase_next  = dlfd_pkg::PH_HUNT;
                end
                else
                begin
                    first_digit_next = rx_byte[3:0];
                    phase_next       = dlfd_pkg::PH_CK2;
                end
            end
            dlfd_pkg::PH_CK2:
            begin
                phase_next = dlfd_pkg::PH_HUNT;
                if (!is_digit)
                begin
                    step_result = '{emit: 1'b1, kind: dlfd_pkg::KIND_FORMAT,
                                    payload: 8'd0, checksum: running_sum_reg};
                end
                else if (two_digit == running_sum_reg)
                begin
                    step_result = '{emit: 1'b1, kind: dlfd_pkg::KIND_GOOD,
                                    payload: 8'd0, checksum: running_sum_reg};
                end
                else
                begin
                    step_result = '{emit: 1'b1, kind: dlfd_pkg::KIND_MISMATCH,
                                    payload: 8'd0, checksum: running_sum_reg};
                end
            end
            default:
            begin
                // Hunt: drop everything but the start byte.
                phase_next = dlfd_pkg::PH_HUNT;
                if (rx_byte == dlfd_pkg::START_BYTE)
                begin
                    running_sum_next   = dlfd_pkg::START_SUM;
                    first_digit_next   = 4'd0;
                    frame_length_next  = 7'd0;
                    payload_count_next = 7'd0;
                    phase_next         = dlfd_pkg::PH_LEN1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= dlfd_pkg::PH_HUNT;
            first_digit_reg   <= 4'd0;
            frame_length_reg  <= 7'd0;
            payload_count_reg <= 7'd0;
            running_sum_reg   <= 7'd0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            first_digit_reg   <= first_digit_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
            running_sum_reg   <= running_sum_next;
        end
    end

    a_phase_known: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= dlfd_pkg::PH_CK2)
        else $error("phase register holds an unused code");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        running_sum_reg < 7'(dlfd_pkg::SUM_MODULUS))
        else $error("running sum left the modulo-100 range");

    a_data_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dlfd_pkg::PH_DATA |-> (frame_length_reg >= 7'(dlfd_pkg::MIN_LENGTH)
                                            && payload_count_reg < data_limit))
        else $error("payload phase entered with a bad length or overran the count");

endmodule

// File: rtl/decimal_length_frame_deframer.sv
// Top level of the decimal-length frame deframer: input register, decode core, result register.
`timescale 1ns / 1ps

// Decimal-length frame deframer. Feed received bytes one request at a time on the
// in_valid/in_ready channel; the block hunts for the start byte 'S', reads two ASCII
// length digits, passes (length - 5) payload bytes straight through as kind 0 results,
// then reads two ASCII checksum digits and ends the frame with one verdict result
// (kind 1 good, 2 checksum mismatch, 3 format error) that carries the byte sum modulo
// 100. Bytes that start or continue nothing give no result. Throughput is one byte per
// clock cycle while out_ready allows: the decode core is combinational between the input
// register and the result register, so the only limit is out_ready. An accepted byte
// waits in the input register; the core decodes it and loads the result register,
// which drives out_valid, once that register is empty or draining.
// in_ready stays high while the result register is empty or being drained.
module decimal_length_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] payload_byte,
    output logic [6:0] computed_checksum
);

    // Input stage.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // Result stage.
    logic       out_valid_reg, out_valid_next;
    logic [1:0] kind_reg;
    logic [7:0] payload_reg;
    logic [6:0] checksum_reg;

    logic              out_free;
    logic              step_en;
    dlfd_pkg::result_t step_result;

    // The result register can take a new value when it is empty or drains this cycle.
    assign out_free = !out_valid_reg || out_ready;
    // Advance the held byte through the core whenever the result side can follow.
    assign step_en  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || step_en;

    dlfd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .rx_byte     (in_byte_reg),
        .step_result (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_en)
        begin
            // Bytes with no result leave the register empty once the old one drains.
            out_valid_next = step_result.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step_en && step_result.emit)
        begin
            kind_reg     <= step_result.kind;
            payload_reg  <= step_result.payload;
            checksum_reg <= step_result.checksum;
        end
    end

    assign out_valid         = out_valid_reg;
    assign result_kind       = kind_reg;
    assign payload_byte      = payload_reg;
    assign computed_checksum = checksum_reg;

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == dlfd_pkg::KIND_PAYLOAD |-> computed_checksum == 7'd0)
        else $error("payload result carries a nonzero checksum");

    a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != dlfd_pkg::KIND_PAYLOAD
        |-> payload_byte == 8'd0 && computed_checksum < 7'(dlfd_pkg::SUM_MODULUS))
        else $error("verdict result carries bad payload or checksum");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked result");

endmodule
